// ===== src/lpgf_pkg.sv =====
`timescale 1ns / 1ps
// Package for the label projection gap finder.
// Holds the transaction structs, code enums and fixed widths; no dependencies.
package lpgf_pkg;

    localparam int LABEL_W     = 16;
    localparam int LABEL_BITS  = 16;
    localparam int SIZE_W      = 9;
    localparam int SLICE_W     = 8;
    localparam int COUNT_W     = 17;
    localparam int CFG_ADDR_W  = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [LABEL_W-1:0] LABEL_MASK =
        (LABEL_BITS >= LABEL_W) ? '1 : LABEL_W'((32'd1 << LABEL_BITS) - 32'd1);

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LABEL  = 2'd0,
        CFG_SIZE_X = 2'd1,
        CFG_SIZE_Y = 2'd2,
        CFG_SIZE_Z = 2'd3
    } cfg_addr_t;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_VOXEL = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    typedef enum logic [1:0] {
        STATUS_GAP         = 2'd0,
        STATUS_SEGMENTED   = 2'd1,
        STATUS_RANGE       = 2'd2,
        STATUS_NO_NEIGHBOR = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VOXEL,
        ST_QHIT,
        ST_QDOWN,
        ST_QUP
    } state_t;

    typedef struct packed {
        mode_t                mode;
        logic [LABEL_W-1:0]   voxel_label;
        axis_t                axis;
        logic [SLICE_W-1:0]   slice_index;
    } in_t;

    typedef struct packed {
        status_t              status;
        logic [SLICE_W-1:0]   lower_slice;
        logic [SLICE_W-1:0]   upper_slice;
        logic [COUNT_W-1:0]   slice_count;
    } out_t;

endpackage

// ===== src/label_projection_gap_finder_top.sv =====
`timescale 1ns / 1ps
// Label projection gap finder: per-axis label counts in three count memories,
// read-modify-write on voxels and a one-read-per-cycle neighbor scan on queries.
// Depends on lpgf_pkg.
//
//  channel  | ports                         | carries
//  ---------+-------------------------------+-----------------------------------
//  input    | s_valid, s_ready, s_data      | clear / voxel / query transaction
//  result   | m_valid, m_ready, m_data      | query status, neighbors, count
//  config   | cfg_wr_en, cfg_addr, cfg_wdata| label and size registers
//
// Voxel: count memory read, then saturating write-back.
// Query: an out-of-range query gives its result at once; else the queried slice is
// read, then slices below it are scanned and, once one holds labels, those above.
// Clear and reset: a zeroing sweep over the MAX_DIM addresses of the count memories,
// with s_ready low. Voxel and clear transactions are taken while a result
// waits on m_*; a query waits until the result register is free.
module label_projection_gap_finder_top #(
    parameter int MAX_DIM = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  lpgf_pkg::in_t                  s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output lpgf_pkg::out_t                 m_data,
    input  logic                           cfg_wr_en,
    input  logic [lpgf_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lpgf_pkg::LABEL_W-1:0]   cfg_wdata
);
    import lpgf_pkg::*;

    localparam int AW = $clog2(MAX_DIM);
    localparam int SW = $clog2(MAX_DIM + 1);
    localparam int CW = (SW > SIZE_W) ? SW : SIZE_W;
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_DIM - 1);

    function automatic logic [SW-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [CW-1:0] v;
        v = CW'(s);
        if (s == '0) begin
            return SW'(1);
        end else if (v > CW'(MAX_DIM)) begin
            return SW'(MAX_DIM);
        end
        return SW'(v);
    endfunction

    // configuration
    logic [LABEL_W-1:0] label_reg;
    logic [SIZE_W-1:0]  size_x_reg, size_y_reg, size_z_reg;

    // control and position
    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [AW-1:0]      pos_x_reg, pos_x_next;
    logic [AW-1:0]      pos_y_reg, pos_y_next;
    logic [AW-1:0]      pos_z_reg, pos_z_next;
    logic               done_reg, done_next;
    logic               match_reg, match_next;
    axis_t              axis_reg, axis_next;
    logic [AW-1:0]      qidx_reg, qidx_next;
    logic [AW-1:0]      scan_reg, scan_next;
    logic [AW-1:0]      lo_reg, lo_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg, m_data_next;

    // count memories
    logic [COUNT_W-1:0] mem_x [MAX_DIM];
    logic [COUNT_W-1:0] mem_y [MAX_DIM];
    logic [COUNT_W-1:0] mem_z [MAX_DIM];
    logic [COUNT_W-1:0] rd_x_reg, rd_y_reg, rd_z_reg;
    logic [AW-1:0]      raddr_x, raddr_y, raddr_z;
    logic [AW-1:0]      waddr_x, waddr_y, waddr_z;
    logic [COUNT_W-1:0] wdata_x, wdata_y, wdata_z;
    logic               mem_we;

    // shared conditions
    logic [SW-1:0]      eff_x, eff_y, eff_z, size_in, size_q;
    logic               in_acc, out_free, query_bad, hit;
    logic               qidx_up_end, scan_up_end;
    logic               wrap_x, wrap_y, wrap_z;
    logic [COUNT_W-1:0] cnt_sel;
    logic [AW-1:0]      qaddr;

    assign eff_x = eff_size(size_x_reg);
    assign eff_y = eff_size(size_y_reg);
    assign eff_z = eff_size(size_z_reg);

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && ((s_data.mode != MODE_QUERY) || out_free);
    assign in_acc   = s_valid && s_ready;

    always_comb begin
        unique case (s_data.axis)
            AXIS_X:  size_in = eff_x;
            AXIS_Y:  size_in = eff_y;
            default: size_in = eff_z;
        endcase
        unique case (axis_reg)
            AXIS_X:  begin size_q = eff_x; cnt_sel = rd_x_reg; end
            AXIS_Y:  begin size_q = eff_y; cnt_sel = rd_y_reg; end
            default: begin size_q = eff_z; cnt_sel = rd_z_reg; end
        endcase
    end

    assign query_bad   = (s_data.axis == AXIS_NONE)
                         || (CW'(s_data.slice_index) >= CW'(size_in));
    assign hit         = (cnt_sel != '0);
    assign qidx_up_end = (SW'(qidx_reg) + SW'(1)) >= size_q;
    assign scan_up_end = (SW'(scan_reg) + SW'(1)) >= size_q;
    assign wrap_x      = (SW'(pos_x_reg) + SW'(1)) >= eff_x;
    assign wrap_y      = (SW'(pos_y_reg) + SW'(1)) >= eff_y;
    assign wrap_z      = (SW'(pos_z_reg) + SW'(1)) >= eff_z;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (s_data.mode)
                        MODE_CLEAR: state_next = ST_CLEAR;
                        MODE_VOXEL: state_next = done_reg ? ST_IDLE : ST_VOXEL;
                        MODE_QUERY: state_next = query_bad ? ST_IDLE : ST_QHIT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_VOXEL: state_next = ST_IDLE;
            ST_QHIT: begin
                if (hit || qidx_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_QDOWN;
                end
            end
            ST_QDOWN: begin
                priority if (hit) begin
                    state_next = qidx_up_end ? ST_IDLE : ST_QUP;
                end else if (scan_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_QDOWN;
                end
            end
            ST_QUP: begin
                if (hit || scan_up_end) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        clr_next     = clr_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        pos_z_next   = pos_z_reg;
        done_next    = done_reg;
        match_next   = match_reg;
        axis_next    = axis_reg;
        qidx_next    = qidx_reg;
        lo_next      = lo_reg;
        qaddr        = scan_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        waddr_x      = pos_x_reg;
        waddr_y      = pos_y_reg;
        waddr_z      = pos_z_reg;
        wdata_x      = (rd_x_reg == COUNT_MAX) ? rd_x_reg : rd_x_reg + COUNT_W'(1);
        wdata_y      = (rd_y_reg == COUNT_MAX) ? rd_y_reg : rd_y_reg + COUNT_W'(1);
        wdata_z      = (rd_z_reg == COUNT_MAX) ? rd_z_reg : rd_z_reg + COUNT_W'(1);

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                waddr_x  = clr_reg;
                waddr_y  = clr_reg;
                waddr_z  = clr_reg;
                wdata_x  = '0;
                wdata_y  = '0;
                wdata_z  = '0;
                clr_next = clr_reg + AW'(1);
            end
            ST_IDLE: begin
                qaddr = AW'(s_data.slice_index);
                if (in_acc) begin
                    unique case (s_data.mode)
                        MODE_CLEAR: begin
                            clr_next   = '0;
                            pos_x_next = '0;
                            pos_y_next = '0;
                            pos_z_next = '0;
                            done_next  = 1'b0;
                        end
                        MODE_VOXEL: begin
                            match_next = ((s_data.voxel_label ^ label_reg) & LABEL_MASK) == '0;
                        end
                        MODE_QUERY: begin
                            axis_next = s_data.axis;
                            qidx_next = AW'(s_data.slice_index);
                            if (query_bad) begin
                                m_valid_next = 1'b1;
                                m_data_next  = '{status: STATUS_RANGE, default: '0};
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_VOXEL: begin
                mem_we = match_reg;
                if (wrap_x) begin
                    pos_x_next = '0;
                    if (wrap_y) begin
                        pos_y_next = '0;
                        if (wrap_z) begin
                            pos_z_next = '0;
                            done_next  = 1'b1;
                        end else begin
                            pos_z_next = pos_z_reg + AW'(1);
                        end
                    end else begin
                        pos_y_next = pos_y_reg + AW'(1);
                    end
                end else begin
                    pos_x_next = pos_x_reg + AW'(1);
                end
            end
            ST_QHIT: begin
                qaddr = qidx_reg - AW'(1);
                if (hit) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: STATUS_SEGMENTED, slice_count: cnt_sel,
                                     default: '0};
                end else if (qidx_reg == '0) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: STATUS_NO_NEIGHBOR, default: '0};
                end
            end
            ST_QDOWN: begin
                priority if (hit) begin
                    lo_next = scan_reg;
                    qaddr   = qidx_reg + AW'(1);
                    if (qidx_up_end) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{status: STATUS_NO_NEIGHBOR, default: '0};
                    end
                end else if (scan_reg == '0) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: STATUS_NO_NEIGHBOR, default: '0};
                end else begin
                    qaddr = scan_reg - AW'(1);
                end
            end
            ST_QUP: begin
                priority if (hit) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: STATUS_GAP, lower_slice: SLICE_W'(lo_reg),
                                     upper_slice: SLICE_W'(scan_reg), default: '0};
                end else if (scan_up_end) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: STATUS_NO_NEIGHBOR, default: '0};
                end else begin
                    qaddr = scan_reg + AW'(1);
                end
            end
            default: ;
        endcase

        scan_next = qaddr;
        if (state_reg == ST_IDLE && s_data.mode != MODE_QUERY) begin
            raddr_x = pos_x_reg;
            raddr_y = pos_y_reg;
            raddr_z = pos_z_reg;
        end else begin
            raddr_x = qaddr;
            raddr_y = qaddr;
            raddr_z = qaddr;
        end
    end

    // count memories: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_x[waddr_x] <= wdata_x;
            mem_y[waddr_y] <= wdata_y;
            mem_z[waddr_z] <= wdata_z;
        end
        rd_x_reg <= mem_x[raddr_x];
        rd_y_reg <= mem_y[raddr_y];
        rd_z_reg <= mem_z[raddr_z];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            pos_z_reg   <= '0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            label_reg   <= '0;
            size_x_reg  <= SIZE_RESET;
            size_y_reg  <= SIZE_RESET;
            size_z_reg  <= SIZE_RESET;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            pos_z_reg   <= pos_z_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr_t'(cfg_addr))
                    CFG_LABEL:  label_reg  <= cfg_wdata;
                    CFG_SIZE_X: size_x_reg <= cfg_wdata[SIZE_W-1:0];
                    CFG_SIZE_Y: size_y_reg <= cfg_wdata[SIZE_W-1:0];
                    CFG_SIZE_Z: size_z_reg <= cfg_wdata[SIZE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        match_reg  <= match_next;
        axis_reg   <= axis_next;
        qidx_reg   <= qidx_next;
        scan_reg   <= scan_next;
        lo_reg     <= lo_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // the result register is free for the whole of a query scan
    a_scan_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_QHIT || state_reg == ST_QDOWN || state_reg == ST_QUP)
            |-> !m_valid_reg)
        else $error("result pending during query scan");

    a_down_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_QDOWN) |-> (scan_reg < qidx_reg))
        else $error("downward scan not below queried slice");

    a_up_above: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_QUP) |-> (scan_reg > qidx_reg))
        else $error("upward scan not above queried slice");

    a_no_update_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_VOXEL) |-> !done_reg)
        else $error("voxel update after volume complete");

    a_sweep_then_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && clr_reg == CLR_LAST) |=> (state_reg == ST_IDLE))
        else $error("clearing sweep did not end");

endmodule

// ===== verif/tb_label_projection_gap_finder_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for label_projection_gap_finder_top: a directed table, then
// random volume/query phases over several register settings, checked by a projection model.
// Depends on lpgf_pkg and the top-level RTL.
module tb_label_projection_gap_finder_top;
    import lpgf_pkg::*;

    localparam int DIM_MAX       = 256;
    localparam int SETTLE_CYCLES = 300;
    localparam int LONG_HOLD     = 600;
    localparam int RANDOM_ITEMS  = 850;
    localparam int TIMEOUT_NS    = 40_000_000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_t                   s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_t                  m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [LABEL_W-1:0]    cfg_wdata = '0;

    label_projection_gap_finder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Projection model state
    logic [COUNT_W-1:0] col_cnt [DIM_MAX];
    logic [COUNT_W-1:0] row_cnt [DIM_MAX];
    logic [COUNT_W-1:0] slc_cnt [DIM_MAX];
    int unsigned        px, py, pz;
    bit                 vol_full;
    logic [LABEL_W-1:0] cfg_label = '0;
    logic [SIZE_W-1:0]  cfg_sx = SIZE_RESET;
    logic [SIZE_W-1:0]  cfg_sy = SIZE_RESET;
    logic [SIZE_W-1:0]  cfg_sz = SIZE_RESET;

    out_t expected_gaps [$];
    int   mismatch_count  = 0;
    int   effective_items = 0;
    int   send_gap_pct    = 0;
    int   stall_pct       = 0;
    bit   hold_trigger    = 1'b0;
    bit   hold_seen       = 1'b0;
    int   hold_left       = 0;

    typedef struct {
        in_t  item;
        bit   typed;
        out_t want;
    } script_row_t;

    script_row_t script_rows [$];

    function automatic void clear_volume();
        for (int i = 0; i < DIM_MAX; i++) begin
            col_cnt[i] = '0;
            row_cnt[i] = '0;
            slc_cnt[i] = '0;
        end
        px = 0;
        py = 0;
        pz = 0;
        vol_full = 1'b0;
    endfunction

    function automatic int unsigned eff_dim(logic [SIZE_W-1:0] s);
        if (s == 0) return 1;
        if (s > DIM_MAX) return DIM_MAX;
        return s;
    endfunction

    function automatic int unsigned axis_dim(axis_t ax);
        case (ax)
            AXIS_X:  return eff_dim(cfg_sx);
            AXIS_Y:  return eff_dim(cfg_sy);
            default: return eff_dim(cfg_sz);
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] count_at(axis_t ax, int i);
        case (ax)
            AXIS_X:  return col_cnt[i];
            AXIS_Y:  return row_cnt[i];
            default: return slc_cnt[i];
        endcase
    endfunction

    function automatic void apply_register(cfg_addr_t a, logic [LABEL_W-1:0] v);
        case (a)
            CFG_LABEL:  cfg_label = v;
            CFG_SIZE_X: cfg_sx = v[SIZE_W-1:0];
            CFG_SIZE_Y: cfg_sy = v[SIZE_W-1:0];
            default:    cfg_sz = v[SIZE_W-1:0];
        endcase
    endfunction

    // Returns 1 when the transaction is a query, with its expected result in res.
    function automatic bit project_item(input in_t it, output out_t res);
        int unsigned dim;
        int          lo;
        int          hi;
        bit          found_lo;
        bit          found_hi;
        res = '0;
        lo = 0;
        hi = 0;
        found_lo = 1'b0;
        found_hi = 1'b0;
        case (it.mode)
            MODE_CLEAR: clear_volume();
            MODE_VOXEL: begin
                if (!vol_full) begin
                    if ((it.voxel_label & LABEL_MASK) == (cfg_label & LABEL_MASK)) begin
                        if (col_cnt[px] != COUNT_MAX) col_cnt[px] += 1'b1;
                        if (row_cnt[py] != COUNT_MAX) row_cnt[py] += 1'b1;
                        if (slc_cnt[pz] != COUNT_MAX) slc_cnt[pz] += 1'b1;
                    end
                    if (px + 1 >= eff_dim(cfg_sx)) begin
                        px = 0;
                        if (py + 1 >= eff_dim(cfg_sy)) begin
                            py = 0;
                            if (pz + 1 >= eff_dim(cfg_sz)) begin
                                pz = 0;
                                vol_full = 1'b1;
                            end else begin
                                pz++;
                            end
                        end else begin
                            py++;
                        end
                    end else begin
                        px++;
                    end
                end
            end
            MODE_QUERY: begin
                dim = axis_dim(it.axis);
                if (it.axis == AXIS_NONE || it.slice_index >= dim) begin
                    res.status = STATUS_RANGE;
                end else begin
                    res.slice_count = count_at(it.axis, it.slice_index);
                    if (res.slice_count != 0) begin
                        res.status = STATUS_SEGMENTED;
                    end else begin
                        for (int i = int'(it.slice_index) - 1; i >= 0 && !found_lo; i--) begin
                            if (count_at(it.axis, i) != 0) begin
                                lo = i;
                                found_lo = 1'b1;
                            end
                        end
                        for (int i = int'(it.slice_index) + 1; i < dim && !found_hi; i++) begin
                            if (count_at(it.axis, i) != 0) begin
                                hi = i;
                                found_hi = 1'b1;
                            end
                        end
                        if (found_lo && found_hi) begin
                            res.status      = STATUS_GAP;
                            res.lower_slice = SLICE_W'(lo);
                            res.upper_slice = SLICE_W'(hi);
                        end else begin
                            res.status = STATUS_NO_NEIGHBOR;
                        end
                    end
                end
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void add_row(mode_t m, logic [LABEL_W-1:0] lbl, axis_t ax,
                                    logic [SLICE_W-1:0] idx, bit typed, status_t st,
                                    int lo, int hi, int cnt);
        script_row_t row;
        row.item.mode        = m;
        row.item.voxel_label = lbl;
        row.item.axis        = ax;
        row.item.slice_index = idx;
        row.typed            = typed;
        row.want.status      = st;
        row.want.lower_slice = SLICE_W'(lo);
        row.want.upper_slice = SLICE_W'(hi);
        row.want.slice_count = COUNT_W'(cnt);
        script_rows.push_back(row);
    endfunction

    task automatic note_mismatch(string what, out_t want, out_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t %s: want st=%0d lo=%0d hi=%0d cnt=%0d got st=%0d lo=%0d hi=%0d cnt=%0d",
                     $realtime, what, want.status, want.lower_slice, want.upper_slice,
                     want.slice_count, got.status, got.lower_slice, got.upper_slice,
                     got.slice_count);
        end
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_gaps.size() == 0) begin
                note_mismatch("unexpected result", '0, m_data);
            end else begin
                want = expected_gaps.pop_front();
                if (m_data.status !== want.status || m_data.lower_slice !== want.lower_slice ||
                    m_data.upper_slice !== want.upper_slice ||
                    m_data.slice_count !== want.slice_count) begin
                    note_mismatch("result mismatch", want, m_data);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Call at a falling edge; returns at the falling edge after the transaction.
    task automatic push_item(in_t it, bit typed, out_t want);
        out_t res;
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (!(it.mode == MODE_NOP || (it.mode == MODE_VOXEL && vol_full))) effective_items++;
        if (project_item(it, res)) expected_gaps.push_back(typed ? want : res);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (expected_gaps.size() != 0);
    endtask

    task automatic settle_block();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_registers(logic [LABEL_W-1:0] lbl, logic [SIZE_W-1:0] sx,
                                   logic [SIZE_W-1:0] sy, logic [SIZE_W-1:0] sz);
        logic [LABEL_W-1:0] wdata [4];
        wdata[0] = lbl;
        wdata[1] = {7'($urandom), sx};
        wdata[2] = {7'($urandom), sy};
        wdata[3] = {7'($urandom), sz};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= cfg_addr_t'(i);
            cfg_wdata <= wdata[i];
            @(posedge aclk);
            apply_register(cfg_addr_t'(i), wdata[i]);
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        in_t               it;
        logic [LABEL_W-1:0] lbl;
        logic [SIZE_W-1:0]  sx, sy, sz;
        int                phase;
        int                cap;
        int                r;
        int                match_pct;
        int                query_pct;
        int unsigned       dim;

        clear_volume();
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        settle_block();

        add_row(MODE_QUERY, 16'h0000, AXIS_X,    8'd0,   1, STATUS_NO_NEIGHBOR, 0, 0, 0);
        add_row(MODE_QUERY, 16'hFFFF, AXIS_NONE, 8'd255, 1, STATUS_RANGE,       0, 0, 0);
        add_row(MODE_QUERY, 16'h0000, AXIS_Z,    8'd255, 1, STATUS_NO_NEIGHBOR, 0, 0, 0);
        add_row(MODE_QUERY, 16'h1234, AXIS_Y,    8'd128, 0, STATUS_GAP,         0, 0, 0);
        add_row(MODE_NOP,   16'hFFFF, AXIS_NONE, 8'd255, 0, STATUS_GAP,         0, 0, 0);
        add_row(MODE_VOXEL, 16'h0000, AXIS_X,    8'd0,   0, STATUS_GAP,         0, 0, 0);
        add_row(MODE_VOXEL, 16'hFFFF, AXIS_NONE, 8'd255, 0, STATUS_GAP,         0, 0, 0);
        add_row(MODE_VOXEL, 16'h0000, AXIS_Y,    8'd17,  0, STATUS_GAP,         0, 0, 0);
        add_row(MODE_QUERY, 16'h0000, AXIS_X,    8'd0,   1, STATUS_SEGMENTED,   0, 0, 1);
        add_row(MODE_QUERY, 16'hFFFF, AXIS_X,    8'd1,   1, STATUS_GAP,         0, 2, 0);
        add_row(MODE_QUERY, 16'h0000, AXIS_X,    8'd2,   0, STATUS_GAP,         0, 0, 0);
        add_row(MODE_QUERY, 16'h0000, AXIS_Y,    8'd0,   1, STATUS_SEGMENTED,   0, 0, 2);
        add_row(MODE_QUERY, 16'h0000, AXIS_Z,    8'd0,   0, STATUS_GAP,         0, 0, 0);
        add_row(MODE_QUERY, 16'h0000, AXIS_Z,    8'd1,   0, STATUS_GAP,         0, 0, 0);
        add_row(MODE_QUERY, 16'h0000, AXIS_X,    8'd255, 0, STATUS_GAP,         0, 0, 0);
        add_row(MODE_VOXEL, 16'h5555, AXIS_X,    8'd85,  0, STATUS_GAP,         0, 0, 0);
        add_row(MODE_VOXEL, 16'hAAAA, AXIS_Z,    8'd170, 0, STATUS_GAP,         0, 0, 0);
        add_row(MODE_QUERY, 16'h0000, AXIS_X,    8'd3,   0, STATUS_GAP,         0, 0, 0);
        add_row(MODE_CLEAR, 16'hFFFF, AXIS_NONE, 8'd255, 0, STATUS_GAP,         0, 0, 0);
        add_row(MODE_QUERY, 16'h0000, AXIS_X,    8'd0,   1, STATUS_NO_NEIGHBOR, 0, 0, 0);
        add_row(MODE_QUERY, 16'h0000, AXIS_Y,    8'd0,   1, STATUS_NO_NEIGHBOR, 0, 0, 0);
        add_row(MODE_QUERY, 16'h0000, AXIS_NONE, 8'd0,   1, STATUS_RANGE,       0, 0, 0);

        foreach (script_rows[i]) push_item(script_rows[i].item, script_rows[i].typed,
                                           script_rows[i].want);

        effective_items = 0;
        phase = 0;
        while (phase < 6 || effective_items < RANDOM_ITEMS) begin
            settle_block();
            lbl = 16'($urandom);
            sx  = SIZE_W'($urandom_range(1, 8));
            sy  = SIZE_W'($urandom_range(1, 8));
            sz  = SIZE_W'($urandom_range(1, 6));
            case (phase)
                0: begin sx = 9'd4; sy = 9'd3; sz = 9'd2; end
                1: begin sx = 9'd256; sy = 9'd1; sz = 9'd1; lbl = 16'hFFFF; end
                2: begin sx = 9'd1; sy = 9'd256; sz = 9'd1; lbl = 16'h0000; end
                3: begin sx = 9'd1; sy = 9'd1; sz = 9'd256; end
                4: begin sx = 9'd0; sy = 9'd0; sz = 9'd0; end
                5: begin
                    sx = SIZE_W'($urandom_range(257, 511));
                    sy = SIZE_W'($urandom_range(257, 511));
                    sz = SIZE_W'($urandom_range(257, 511));
                end
                default: begin
                    if ($urandom_range(9) == 0) sx = SIZE_W'($urandom_range(511));
                    if ($urandom_range(9) == 0) sy = SIZE_W'($urandom_range(511));
                    if ($urandom_range(9) == 0) sz = SIZE_W'($urandom_range(511));
                end
            endcase
            write_registers(lbl, sx, sy, sz);

            case (phase % 4)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 62; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 62; end
                default: begin send_gap_pct = 8; stall_pct = 8; end
            endcase
            if (phase == 0) hold_trigger = !hold_trigger;

            // keep the volume open on some phases so the new sizes land mid-volume
            if (phase < 6 || $urandom_range(1) == 1) begin
                it = '0;
                it.mode = MODE_CLEAR;
                push_item(it, 1'b0, '0);
            end

            cap = $urandom_range(40, 80);
            case ($urandom_range(2))
                0:       match_pct = 15;
                1:       match_pct = 50;
                default: match_pct = 85;
            endcase
            query_pct = $urandom_range(15, 35);
            for (int k = 0; k < cap; k++) begin
                if (k == cap / 2 && phase % 3 == 2) drain_results();
                r = $urandom_range(99);
                it.mode        = mode_t'($urandom_range(3));
                it.voxel_label = 16'($urandom);
                it.axis        = axis_t'($urandom_range(3));
                it.slice_index = 8'($urandom);
                if (r >= 8) begin
                    if (r < 8 + query_pct || (vol_full && $urandom_range(4) != 0)) begin
                        it.mode = MODE_QUERY;
                        it.axis = ($urandom_range(9) == 0) ? AXIS_NONE
                                                           : axis_t'($urandom_range(2));
                        dim = axis_dim(it.axis);
                        if (it.axis != AXIS_NONE && $urandom_range(9) < 7)
                            it.slice_index = SLICE_W'($urandom_range(dim - 1));
                    end else begin
                        it.mode = MODE_VOXEL;
                        if ($urandom_range(99) < match_pct) it.voxel_label = cfg_label;
                    end
                end
                push_item(it, 1'b0, '0);
            end
            phase++;
        end

        settle_block();
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
